// ===== rtl/core/ffla_pkg.sv =====
// Package for the free-list allocator: pool size, codes, payload and control types.
package ffla_pkg;

    // Pool size and derived widths
    localparam int unsigned NUM_SLOTS = 32;
    localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int unsigned FIELD_W   = 5;
    localparam int unsigned IDX_W     = (SLOT_W > FIELD_W) ? SLOT_W : FIELD_W;

    // Request codes
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    // Response codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FREED     = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        t_func              func;
        logic [FIELD_W-1:0] slot_to_free;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] slot_granted;
    } t_rsp;

    // Per-cell control: shift toward the head, or load a freed slot
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ffla_cell.sv =====
// One cell of the free-slot queue: holds one slot index and hands it toward the head.
module ffla_cell
    import ffla_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot     i_rst_slot,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_next_slot,
    input  t_slot     i_load_slot,
    output t_slot     o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // Pick the next value: load a freed slot, take the neighbor's, or hold
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load) begin
            n_slot = i_load_slot;
        end else if (i_ctl.shift) begin
            n_slot = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= i_rst_slot;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/core/fifo_free_list_allocator_core.sv =====
// Top level of the fixed-pool free-list allocator.
// A fixed pool of NUM_SLOTS slots is kept as a FIFO of free slot indices in a row of
// cells, cell 0 being the head; after reset every slot is free, queued in index order.
// A request is taken in any cycle in which the response register is empty or being
// drained, and its response appears in that register on the next cycle, so the block
// sustains one request per cycle while responses are drained. The rate is set by the
// cell row: an allocate shifts every cell one place toward the head, and a free loads
// the cell just past the last occupied one. Duplicate frees are caught by a per-slot
// free mark. Reset takes effect at once; there is no clearing pass.
module fifo_free_list_allocator_core
    import ffla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [NUM_SLOTS-1:0] r_free_mark;
    logic [NUM_SLOTS-1:0] n_free_mark;
    logic                 r_rsp_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;

    logic                 req_xfer;
    logic                 list_empty;
    logic [IDX_W:0]       slot_ext;
    logic                 slot_in_range;
    t_slot                slot_idx;
    logic                 dup;
    logic                 do_pop;
    logic                 do_push;
    t_slot                head_slot;
    logic [IDX_W-1:0]     head_ext;

    t_slot                cell_slot [NUM_SLOTS];
    t_cell_ctl            cell_ctl  [NUM_SLOTS];

    // Request handshake: the response register parts the two sides
    assign o_req_ready = !r_rsp_valid || i_rsp_ready;
    assign req_xfer    = i_req_valid && o_req_ready;

    // Decode the request against the queue state
    assign list_empty    = (r_count == '0);
    assign slot_ext      = (IDX_W + 1)'(i_req.slot_to_free);
    assign slot_in_range = (slot_ext < (IDX_W + 1)'(NUM_SLOTS));
    assign slot_idx      = slot_ext[SLOT_W-1:0];
    assign dup           = !slot_in_range || r_free_mark[slot_idx];
    assign do_pop        = req_xfer && (i_req.func == FUNC_ALLOC) && !list_empty;
    assign do_push       = req_xfer && (i_req.func == FUNC_FREE) && !dup;
    assign head_slot     = cell_slot[0];
    assign head_ext      = IDX_W'(head_slot);

    // Row of queue cells, cell 0 is the head
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        t_slot nbr_slot;
        if (k == NUM_SLOTS - 1) begin : g_last
            assign nbr_slot = '0;
        end else begin : g_mid
            assign nbr_slot = cell_slot[k+1];
        end

        assign cell_ctl[k].shift = do_pop;
        assign cell_ctl[k].load  = do_push && (r_count == CNT_W'(k));

        ffla_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rst_slot  (SLOT_W'(k)),
            .i_ctl       (cell_ctl[k]),
            .i_next_slot (nbr_slot),
            .i_load_slot (slot_idx),
            .o_slot      (cell_slot[k])
        );
    end

    // Next fill count, free marks and response
    always_comb begin
        n_count     = r_count;
        n_free_mark = r_free_mark;
        n_rsp       = r_rsp;
        if (req_xfer) begin
            n_rsp.slot_granted = '0;
            if (i_req.func == FUNC_ALLOC) begin
                if (list_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.status             = ST_ALLOCATED;
                    n_rsp.slot_granted       = head_ext[FIELD_W-1:0];
                    n_count                  = r_count - CNT_W'(1);
                    n_free_mark[head_slot]   = 1'b0;
                end
            end else begin
                if (dup) begin
                    n_rsp.status = ST_DUPLICATE;
                end else begin
                    n_rsp.status           = ST_FREED;
                    n_count                = r_count + CNT_W'(1);
                    n_free_mark[slot_idx]  = 1'b1;
                end
            end
        end
    end

    // Hold the queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(NUM_SLOTS);
            r_free_mark <= '1;
        end else begin
            r_count     <= n_count;
            r_free_mark <= n_free_mark;
        end
    end

    // Response register: load on a request transfer, drop on a response transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (req_xfer) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/ffla_checker.sv =====
// Port-level checks for the free-list allocator, bound to the top level.
module ffla_props
    import ffla_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // A granted index is only reported with an allocation
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_ALLOCATED) |-> (o_rsp.slot_granted == '0))
        else $error("slot_granted nonzero without allocation");

    // Every request transfer yields a response on the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> o_rsp_valid)
        else $error("request transfer without response");

    // An empty response register never stalls requests
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp_valid |-> o_req_ready)
        else $error("request stalled while response register empty");

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind fifo_free_list_allocator_core ffla_props u_ffla_props (.*);

// ===== tb/ffla_checker.sv =====
// Response checker for the free-list allocator: mirrors the pool and compares every response.
module ffla_checker
    import ffla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_grants,
    output int   o_refusals,
    output int   o_returns,
    output int   o_duplicates
);

    localparam int MAX_REPORTS = 20;

    // Mirror of the free list: successor links, per-slot free marks, head and tail
    t_slot succ_slot [NUM_SLOTS];
    logic  slot_free [NUM_SLOTS];
    t_slot first_free;
    t_slot last_free;
    logic  pool_dry;

    // Responses owed by the block, oldest first
    t_rsp  owed_rsp [$];
    int    fails;
    int    grants;
    int    refusals;
    int    returns;
    int    duplicates;

    // Queue every slot in index order
    function automatic void refill_pool();
        for (int k = 0; k < NUM_SLOTS; k++) begin
            succ_slot[k] = t_slot'((k + 1) % NUM_SLOTS);
            slot_free[k] = 1'b1;
        end
        first_free = '0;
        last_free  = t_slot'(NUM_SLOTS - 1);
        pool_dry   = 1'b0;
    endfunction

    // Apply one request to the mirror and return the response it earns
    function automatic t_rsp serve_request(t_req req);
        t_rsp rsp;
        int   idx;
        rsp = '0;
        idx = int'(req.slot_to_free);
        if (req.func == FUNC_ALLOC) begin
            if (pool_dry) begin
                rsp.status = ST_EMPTY;
            end else begin
                rsp.status       = ST_ALLOCATED;
                rsp.slot_granted = FIELD_W'(first_free);
                slot_free[first_free] = 1'b0;
                // Taking the last free slot leaves the list empty
                if (first_free == last_free) begin
                    pool_dry = 1'b1;
                end else begin
                    first_free = succ_slot[first_free];
                end
            end
        end else if (idx >= NUM_SLOTS || slot_free[idx]) begin
            rsp.status = ST_DUPLICATE;
        end else begin
            // A slot freed into an empty list becomes head and tail at once
            if (pool_dry) begin
                first_free = t_slot'(idx);
                pool_dry   = 1'b0;
            end else begin
                succ_slot[last_free] = t_slot'(idx);
            end
            last_free      = t_slot'(idx);
            slot_free[idx] = 1'b1;
            rsp.status     = ST_FREED;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            refill_pool();
            owed_rsp.delete();
        end else begin
            // Match a response transfer against the oldest owed response
            if (i_rsp_valid && i_rsp_ready) begin
                if (owed_rsp.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $error("unexpected response: status %0d slot_granted %0d",
                               i_rsp.status, i_rsp.slot_granted);
                    fails++;
                end else begin
                    want = owed_rsp.pop_front();
                    if (i_rsp.status !== want.status) begin
                        if (fails < MAX_REPORTS)
                            $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        fails++;
                    end
                    if (i_rsp.slot_granted !== want.slot_granted) begin
                        if (fails < MAX_REPORTS)
                            $error("slot_granted: expected %0d, got %0d",
                                   want.slot_granted, i_rsp.slot_granted);
                        fails++;
                    end
                    case (want.status)
                        ST_ALLOCATED: grants++;
                        ST_EMPTY:     refusals++;
                        ST_FREED:     returns++;
                        default:      duplicates++;
                    endcase
                end
            end
            // Predict the response to a request transfer
            if (i_req_valid && i_req_ready)
                owed_rsp.push_back(serve_request(i_req));
        end
        o_outstanding <= owed_rsp.size();
        o_fail_count  <= fails;
        o_grants      <= grants;
        o_refusals    <= refusals;
        o_returns     <= returns;
        o_duplicates  <= duplicates;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the free-list allocator: request stimulus, response stalls and verdict.
module tb_top
    import ffla_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ROUNDS = 25;
    localparam int ROUND_LEN     = 50;
    localparam int QUIET_ROUNDS  = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    int   fail_count;
    int   outstanding;
    int   grants;
    int   refusals;
    int   returns;
    int   duplicates;
    int   gap_pct;
    int   stall_pct;
    int   alloc_pct;
    int   sent;
    int   cycles;

    fifo_free_list_allocator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    ffla_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .i_req_ready   (o_req_ready),
        .i_req         (i_req),
        .i_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .i_rsp         (o_rsp),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_grants      (grants),
        .o_refusals    (refusals),
        .o_returns     (returns),
        .o_duplicates  (duplicates)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the response channel in random bursts
    initial begin
        i_rsp_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_rsp_ready <= 1'b1;
        end
    end

    // Present one request and hold it until the transfer; returns on a falling edge
    task automatic issue(input t_func func, input logic [FIELD_W-1:0] slot);
        t_req req;
        req.func         = func;
        req.slot_to_free = slot;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Drop valid and hold off new requests until every response has come back
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        alloc_pct   = 50;
        sent        = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: duplicate frees of a full pool, then a few grants and returns
        issue(FUNC_FREE, '0);
        issue(FUNC_FREE, '1);
        issue(FUNC_ALLOC, '1);
        issue(FUNC_ALLOC, '0);
        issue(FUNC_FREE, FIELD_W'(1));
        issue(FUNC_FREE, '0);
        issue(FUNC_FREE, '0);
        // Drain the whole pool and ask once more
        repeat (NUM_SLOTS + 1) issue(FUNC_ALLOC, FIELD_W'($urandom));
        // Free into an empty list, take that last slot, then ask an empty pool
        issue(FUNC_FREE, '1);
        issue(FUNC_ALLOC, '0);
        issue(FUNC_ALLOC, '1);
        issue(FUNC_FREE, FIELD_W'(17));
        issue(FUNC_FREE, FIELD_W'(17));
        issue(FUNC_ALLOC, '0);
        drain_responses();

        // Random rounds: pick a draining, refilling or even bias at random, vary idling
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            case ($urandom_range(0, 2))
                0:       alloc_pct = 85;
                1:       alloc_pct = 15;
                default: alloc_pct = 50;
            endcase
            if (r >= RANDOM_ROUNDS - QUIET_ROUNDS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(0, 2) * 20;
                stall_pct = $urandom_range(0, 2) * 20;
            end
            for (int n = 0; n < ROUND_LEN; n++) begin
                if ($urandom_range(0, 99) < alloc_pct)
                    issue(FUNC_ALLOC, FIELD_W'($urandom));
                else
                    issue(FUNC_FREE, FIELD_W'($urandom));
            end
            if (r == RANDOM_ROUNDS / 2)
                drain_responses();
        end

        // Wind down and let the last response settle
        drain_responses();
        repeat (4) @(negedge i_clk);

        $display("Covered %0d requests: directed pool drain and refill, then random rounds",
                 sent);
        $display("with idle gaps and stalls; %0d grants, %0d refusals, %0d frees, %0d duplicates",
                 grants, refusals, returns, duplicates);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ffla_pkg.sv
rtl/core/ffla_cell.sv
rtl/core/fifo_free_list_allocator_core.sv
rtl/core/ffla_checker.sv
tb/ffla_checker.sv
tb/tb_top.sv
